FILE: src/wakeup_strobe_framer_unit_defines.svh
// Assertion macros shared by the wake-up strobe framer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef WAKEUP_STROBE_FRAMER_UNIT_DEFINES_SVH
`define WAKEUP_STROBE_FRAMER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define WSF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define WSF_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSF_ASSERT(lbl, clk, rstn, prop, msg)
`define WSF_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

FILE: src/wsf_pkg.sv
// Types and constants of the wake-up strobe framer.
// Depends on nothing; imported by every module of the block.
package wsf_pkg;

  localparam logic [15:0] BCAST_ID = 16'hFFFF;

  // Register reset values.
  localparam logic [15:0] OWN_ID_RST     = 16'd0;
  localparam logic [7:0]  STROBE_MAX_RST = 8'd20;
  localparam logic [7:0]  BCAST_MAX_RST  = 8'd20;
  localparam logic [15:0] INTERVAL_RST   = 16'd10;
  localparam logic [15:0] TRANS_RST      = 16'd2;
  localparam logic [7:0]  STROBE_TYPE_RST = 8'd1;
  localparam logic [7:0]  ACK_TYPE_RST   = 8'd2;

  localparam int ADDR_W = 5;

  typedef enum logic [1:0] {
    OP_STROBE = 2'd0,
    OP_ACK    = 2'd1,
    OP_PARSE  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LAST      = 3'd1,
    ST_BCAST_NA  = 3'd2,
    ST_BAD_ACK   = 3'd3,
    ST_UNSUPP    = 3'd4,
    ST_NOT_ADDR  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_OWN_ID      = 3'd0,
    REG_STROBE_MAX  = 3'd1,
    REG_BCAST_MAX   = 3'd2,
    REG_INTERVAL    = 3'd3,
    REG_TRANS       = 3'd4,
    REG_STROBE_TYPE = 3'd5,
    REG_ACK_TYPE    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] dest_id;
    logic [7:0]  rx_type;
    logic [7:0]  rx_count;
    logic [15:0] rx_id;
  } in_req_t;

  typedef struct packed {
    logic        frame_valid;
    logic [7:0]  type_byte;
    logic [7:0]  frame_seq;
    logic [15:0] frame_id;
    logic [23:0] delay;
    logic [2:0]  status;
  } out_rsp_t;

  typedef struct packed {
    logic [15:0] own_id;
    logic [7:0]  strobe_max;
    logic [7:0]  broadcast_max;
    logic [15:0] strobe_interval;
    logic [15:0] transition_time;
    logic [7:0]  strobe_type_code;
    logic [7:0]  ack_type_code;
  } cfg_t;

endpackage

FILE: src/wsf_cfg.sv
// Configuration register file with an APB-style slave port.
// Depends on wsf_pkg for the register map and the cfg_t bundle.
module wsf_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wsf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output wsf_pkg::cfg_t              cfg
);
  import wsf_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id           <= OWN_ID_RST;
      cfg_r.strobe_max       <= STROBE_MAX_RST;
      cfg_r.broadcast_max    <= BCAST_MAX_RST;
      cfg_r.strobe_interval  <= INTERVAL_RST;
      cfg_r.transition_time  <= TRANS_RST;
      cfg_r.strobe_type_code <= STROBE_TYPE_RST;
      cfg_r.ack_type_code    <= ACK_TYPE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_OWN_ID:      cfg_r.own_id           <= pwdata[15:0];
        REG_STROBE_MAX:  cfg_r.strobe_max       <= pwdata[7:0];
        REG_BCAST_MAX:   cfg_r.broadcast_max    <= pwdata[7:0];
        REG_INTERVAL:    cfg_r.strobe_interval  <= pwdata[15:0];
        REG_TRANS:       cfg_r.transition_time  <= pwdata[15:0];
        REG_STROBE_TYPE: cfg_r.strobe_type_code <= pwdata[7:0];
        REG_ACK_TYPE:    cfg_r.ack_type_code    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OWN_ID:      prdata = {16'd0, cfg_r.own_id};
      REG_STROBE_MAX:  prdata = {24'd0, cfg_r.strobe_max};
      REG_BCAST_MAX:   prdata = {24'd0, cfg_r.broadcast_max};
      REG_INTERVAL:    prdata = {16'd0, cfg_r.strobe_interval};
      REG_TRANS:       prdata = {16'd0, cfg_r.transition_time};
      REG_STROBE_TYPE: prdata = {24'd0, cfg_r.strobe_type_code};
      REG_ACK_TYPE:    prdata = {24'd0, cfg_r.ack_type_code};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

FILE: src/wsf_core.sv
// Framer datapath: strobe counters, ACK bookkeeping and frame parsing.
// Depends on wsf_pkg; the result is combinational from the staged request.
module wsf_core (
  input  logic              clk,
  input  logic              rst_n,
  input  wsf_pkg::cfg_t     cfg,
  input  logic              fire,
  input  wsf_pkg::in_req_t  req,
  output wsf_pkg::out_rsp_t rsp
);
  import wsf_pkg::*;

  logic [7:0]  ucnt_r, ucnt_nxt;
  logic [7:0]  bcnt_r, bcnt_nxt;
  logic        bseen_r, bseen_nxt;
  logic [23:0] pend_r, pend_nxt;
  logic [7:0]  aseq_r, aseq_nxt;

  logic [23:0] prod;
  logic [23:0] ack_dly;
  logic [8:0]  ucnt_inc;

  // Count times interval, less the radio turnaround, floored at zero.
  assign prod     = 24'(req.rx_count * cfg.strobe_interval);
  assign ack_dly  = (prod > {8'd0, cfg.transition_time}) ?
                    (prod - {8'd0, cfg.transition_time}) : 24'd0;
  assign ucnt_inc = {1'b0, ucnt_r} + 9'd1;

  always_comb begin
    ucnt_nxt  = ucnt_r;
    bcnt_nxt  = bcnt_r;
    bseen_nxt = bseen_r;
    pend_nxt  = pend_r;
    aseq_nxt  = aseq_r;
    rsp       = '0;
    unique case (opcode_t'(req.opcode))
      OP_STROBE: begin
        rsp.frame_valid = 1'b1;
        rsp.type_byte   = cfg.strobe_type_code;
        rsp.frame_id    = req.dest_id;
        rsp.status      = ST_OK;
        if (req.dest_id == BCAST_ID) begin
          rsp.frame_seq = bcnt_r;
          if (bcnt_r != 8'd0) begin
            bcnt_nxt = bcnt_r - 8'd1;
          end else begin
            bcnt_nxt   = cfg.broadcast_max;
            rsp.status = ST_LAST;
          end
        end else begin
          rsp.frame_seq = ucnt_r;
          if (ucnt_r != 8'd0) begin
            ucnt_nxt = ucnt_r - 8'd1;
          end else begin
            ucnt_nxt   = cfg.strobe_max;
            rsp.status = ST_LAST;
          end
        end
      end
      OP_ACK: begin
        rsp.delay = pend_r;
        pend_nxt  = 24'd0;
        if (bseen_r) begin
          bseen_nxt  = 1'b0;
          rsp.status = ST_BCAST_NA;
        end else begin
          rsp.frame_valid = 1'b1;
          rsp.type_byte   = cfg.ack_type_code;
          rsp.frame_seq   = aseq_r;
          rsp.frame_id    = cfg.own_id;
          rsp.status      = ST_OK;
        end
      end
      OP_PARSE: begin
        rsp.type_byte = req.rx_type;
        // A strobe match wins when both type codes are equal.
        priority if (req.rx_type == cfg.strobe_type_code) begin
          if (req.rx_id == cfg.own_id) begin
            pend_nxt   = ack_dly;
            aseq_nxt   = req.rx_count;
            rsp.status = ST_OK;
          end else if (req.rx_id == BCAST_ID) begin
            bseen_nxt  = 1'b1;
            pend_nxt   = ack_dly;
            rsp.status = ST_OK;
          end else begin
            rsp.status = ST_NOT_ADDR;
          end
        end else if (req.rx_type == cfg.ack_type_code) begin
          if (req.rx_id == req.dest_id && {1'b0, req.rx_count} == ucnt_inc) begin
            ucnt_nxt   = cfg.strobe_max;
            rsp.status = ST_OK;
          end else begin
            rsp.status = ST_BAD_ACK;
          end
        end else begin
          rsp.status = ST_UNSUPP;
        end
      end
      default: begin
        rsp.status = ST_UNSUPP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ucnt_r  <= STROBE_MAX_RST;
      bcnt_r  <= BCAST_MAX_RST;
      bseen_r <= 1'b0;
      pend_r  <= 24'd0;
      aseq_r  <= 8'd0;
    end else if (fire) begin
      ucnt_r  <= ucnt_nxt;
      bcnt_r  <= bcnt_nxt;
      bseen_r <= bseen_nxt;
      pend_r  <= pend_nxt;
      aseq_r  <= aseq_nxt;
    end
  end

endmodule

FILE: src/wakeup_strobe_framer_unit.sv
// Wake-up strobe framer: an accepted request passes the request register, then the result register.
// One request per cycle is sustained while out_stall is low; the one 8x16 multiply,
// the delay floor and the counter updates all sit between the two registers.
// Reset (rst_n low, synchronous) empties both stages, loads the register reset
// values and reloads both strobe counters; the APB port reads back registers.
`include "wakeup_strobe_framer_unit_defines.svh"
module wakeup_strobe_framer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  wsf_pkg::in_req_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output wsf_pkg::out_rsp_t          out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wsf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import wsf_pkg::*;

  cfg_t     cfg;
  in_req_t  req_r;
  logic     req_vld_r;
  out_rsp_t rsp;
  out_rsp_t rsp_r;
  logic     rsp_vld_r;
  logic     adv;

  // The result register takes a new value whenever it is empty or being drained.
  // The request register moves forward at the same time, so a request sits in
  // it only while the result register is full and stalled.
  assign adv      = !rsp_vld_r || !out_stall;
  assign in_stall = req_vld_r && !adv;

  assign out_valid = rsp_vld_r;
  assign out_data  = rsp_r;

  wsf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // State in the core changes only when the staged request moves on, so each
  // request sees exactly the state left by the one before it.
  wsf_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (req_vld_r && adv),
    .req   (req_r),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      rsp_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        rsp_vld_r <= req_vld_r;
      end
      if (!in_stall) begin
        req_vld_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r <= in_data;
    end
    if (adv && req_vld_r) begin
      rsp_r <= rsp;
    end
  end

  // Stall toward the source only ever comes from a held request.
  `WSF_ASSERT(a_stall_needs_req, clk, rst_n, in_stall |-> req_vld_r, "stall without held request")
  // A result appears only after a request stood in the request register.
  `WSF_ASSERT(a_rsp_from_req, clk, rst_n, $rose(rsp_vld_r) |-> $past(req_vld_r), "result from nothing")
  // A last-strobe report always comes with a built frame.
  `WSF_ASSERT(a_last_has_frame, clk, rst_n, (rsp_vld_r && rsp_r.status == ST_LAST) |-> rsp_r.frame_valid, "last strobe without frame")
  // The first cycle out of reset shows no result.
  `WSF_ASSERT_NORST(a_reset_empty, clk, $rose(rst_n) |-> (!rsp_vld_r && !req_vld_r), "stages not empty after reset")

endmodule

FILE: test/tb_wakeup_strobe_framer_unit.sv
// Self-checking testbench for the wake-up strobe framer: directed corner cases, then
// randomized request traffic under several register settings, checked against a predictor.
// Depends on wsf_pkg and the wakeup_strobe_framer_unit RTL only.
module tb_wakeup_strobe_framer_unit;
  import wsf_pkg::*;

  // Opcode 3 has no member in the package enum; the block answers it as unsupported.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Cycles without any accepted request or result before the run is declared hung.
  localparam int HANG_LIMIT = 5000;
  localparam int RANDOM_PHASES = 7;
  localparam int REQS_PER_PHASE = 250;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BURSTY
  } stall_mode_t;

  typedef enum int {
    CFG_TYPICAL,
    CFG_ALL_ZERO,
    CFG_ALL_ONES
  } cfg_flavor_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_req_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_rsp_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wakeup_strobe_framer_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Predictor state: a private copy of the registers and of the framer
  // state, advanced once per accepted request in acceptance order.
  // ------------------------------------------------------------------
  cfg_t        cfg_mirror;
  logic [7:0]  uni_cnt;
  logic [7:0]  bc_cnt;
  logic        bc_strobe_heard;
  logic [23:0] held_ack_delay;
  logic [7:0]  held_ack_seq;

  out_rsp_t    pending_frames_q[$];
  int          mismatch_cnt = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_run = 0;

  task automatic reset_predictor();
    cfg_mirror.own_id           = OWN_ID_RST;
    cfg_mirror.strobe_max       = STROBE_MAX_RST;
    cfg_mirror.broadcast_max    = BCAST_MAX_RST;
    cfg_mirror.strobe_interval  = INTERVAL_RST;
    cfg_mirror.transition_time  = TRANS_RST;
    cfg_mirror.strobe_type_code = STROBE_TYPE_RST;
    cfg_mirror.ack_type_code    = ACK_TYPE_RST;
    uni_cnt         = STROBE_MAX_RST;
    bc_cnt          = BCAST_MAX_RST;
    bc_strobe_heard = 1'b0;
    held_ack_delay  = '0;
    held_ack_seq    = '0;
  endtask

  // ACK delay for a received strobe count: count * interval less the radio
  // turnaround time, never below zero. The product always fits in 24 bits.
  function automatic logic [23:0] ack_delay(input logic [7:0] cnt);
    logic [23:0] prod;
    prod = 24'(cnt) * 24'(cfg_mirror.strobe_interval);
    if (cnt == 8'd0 || prod <= 24'(cfg_mirror.transition_time)) begin
      return '0;
    end
    return prod - 24'(cfg_mirror.transition_time);
  endfunction

  // Works out the one result a request produces and advances the state.
  function automatic out_rsp_t framer_predict(input in_req_t r);
    out_rsp_t f;
    f = '0;
    case (r.opcode)
      OP_STROBE: begin
        f.frame_valid = 1'b1;
        f.type_byte   = cfg_mirror.strobe_type_code;
        f.frame_id    = r.dest_id;
        f.status      = ST_OK;
        if (r.dest_id == BCAST_ID) begin
          f.frame_seq = bc_cnt;
          if (bc_cnt != 8'd0) begin
            bc_cnt = bc_cnt - 8'd1;
          end else begin
            bc_cnt   = cfg_mirror.broadcast_max;
            f.status = ST_LAST;
          end
        end else begin
          f.frame_seq = uni_cnt;
          if (uni_cnt != 8'd0) begin
            uni_cnt = uni_cnt - 8'd1;
          end else begin
            uni_cnt  = cfg_mirror.strobe_max;
            f.status = ST_LAST;
          end
        end
      end
      OP_ACK: begin
        f.delay        = held_ack_delay;
        held_ack_delay = '0;
        if (bc_strobe_heard) begin
          // Nobody acknowledges a broadcast strobe; only the delay is reported.
          bc_strobe_heard = 1'b0;
          f.status        = ST_BCAST_NA;
        end else begin
          f.frame_valid = 1'b1;
          f.type_byte   = cfg_mirror.ack_type_code;
          f.frame_seq   = held_ack_seq;
          f.frame_id    = cfg_mirror.own_id;
          f.status      = ST_OK;
        end
      end
      OP_PARSE: begin
        f.type_byte = r.rx_type;
        // The strobe type wins when both type codes are equal.
        if (r.rx_type == cfg_mirror.strobe_type_code) begin
          if (r.rx_id == cfg_mirror.own_id) begin
            held_ack_delay = ack_delay(r.rx_count);
            held_ack_seq   = r.rx_count;
            f.status       = ST_OK;
          end else if (r.rx_id == BCAST_ID) begin
            bc_strobe_heard = 1'b1;
            held_ack_delay  = ack_delay(r.rx_count);
            f.status        = ST_OK;
          end else begin
            f.status = ST_NOT_ADDR;
          end
        end else if (r.rx_type == cfg_mirror.ack_type_code) begin
          // Nine-bit compare: a counter at 255 expects 256, which never arrives.
          if (r.rx_id == r.dest_id && {1'b0, r.rx_count} == {1'b0, uni_cnt} + 9'd1) begin
            uni_cnt  = cfg_mirror.strobe_max;
            f.status = ST_OK;
          end else begin
            f.status = ST_BAD_ACK;
          end
        end else begin
          f.status = ST_UNSUPP;
        end
      end
      default: begin
        f.status = ST_UNSUPP;
      end
    endcase
    return f;
  endfunction

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_frame(input out_rsp_t got);
    out_rsp_t want;
    if (pending_frames_q.size() == 0) begin
      mismatch_cnt++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
    end else begin
      want = pending_frames_q.pop_front();
      compare_field("frame_valid", 32'(want.frame_valid), 32'(got.frame_valid));
      compare_field("type_byte", 32'(want.type_byte), 32'(got.type_byte));
      compare_field("frame_seq", 32'(want.frame_seq), 32'(got.frame_seq));
      compare_field("frame_id", 32'(want.frame_id), 32'(got.frame_id));
      compare_field("delay", 32'(want.delay), 32'(got.delay));
      compare_field("status", 32'(want.status), 32'(got.status));
    end
  endtask

  // The result side checks every accepted result and then picks its next stall
  // value. Stall modes run for random stretches, so long clean runs alternate
  // with light, heavy and regular back-pressure.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_frame(out_data);
    end
    if (stall_run == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_run  = $urandom_range(16, 160);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_run % 8) < 3;
    endcase
  end

  // A run that stops moving in both directions is hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Register port
  // ------------------------------------------------------------------
  // One transfer: setup cycle, access cycle, done at the edge where pready is high.
  task automatic apb_transfer(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] mirror_value(input reg_idx_t idx);
    case (idx)
      REG_OWN_ID:      return 32'(cfg_mirror.own_id);
      REG_STROBE_MAX:  return 32'(cfg_mirror.strobe_max);
      REG_BCAST_MAX:   return 32'(cfg_mirror.broadcast_max);
      REG_INTERVAL:    return 32'(cfg_mirror.strobe_interval);
      REG_TRANS:       return 32'(cfg_mirror.transition_time);
      REG_STROBE_TYPE: return 32'(cfg_mirror.strobe_type_code);
      default:         return 32'(cfg_mirror.ack_type_code);
    endcase
  endfunction

  task automatic readback_reg(input reg_idx_t idx);
    logic [31:0] got;
    apb_transfer(1'b0, idx, '0, got);
    compare_field($sformatf("register %0d readback", idx), mirror_value(idx), got);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] unused;
    apb_transfer(1'b1, idx, val, unused);
    case (idx)
      REG_OWN_ID:      cfg_mirror.own_id           = val[15:0];
      REG_STROBE_MAX:  cfg_mirror.strobe_max       = val[7:0];
      REG_BCAST_MAX:   cfg_mirror.broadcast_max    = val[7:0];
      REG_INTERVAL:    cfg_mirror.strobe_interval  = val[15:0];
      REG_TRANS:       cfg_mirror.transition_time  = val[15:0];
      REG_STROBE_TYPE: cfg_mirror.strobe_type_code = val[7:0];
      default:         cfg_mirror.ack_type_code    = val[7:0];
    endcase
    readback_reg(idx);
  endtask

  // ------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------
  // Sends one request. Requests go out in bursts of random length separated by
  // random gaps; the expectation is queued at the edge the request is taken.
  task automatic send_req(input in_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_frames_q.push_back(framer_predict(r));
  endtask

  function automatic in_req_t mk_req(input logic [1:0] op, input logic [15:0] dest,
                                     input logic [7:0] rtype, input logic [7:0] rcount,
                                     input logic [15:0] rid);
    in_req_t r;
    r.opcode   = op;
    r.dest_id  = dest;
    r.rx_type  = rtype;
    r.rx_count = rcount;
    r.rx_id    = rid;
    return r;
  endfunction

  // Stops sending and waits until every result is back. Each request yields
  // exactly one result, so a short pause after the last one leaves the block idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_frames_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  // Random request shaped after real traffic: strobes, ACK builds, strobes
  // heard for this node or broadcast, ACKs that mostly match the unicast
  // counter, and some plain noise. Unused fields stay random.
  function automatic in_req_t random_req();
    in_req_t r;
    int pick;
    r.opcode   = OP_STROBE;
    r.dest_id  = 16'($urandom);
    r.rx_type  = 8'($urandom);
    r.rx_count = 8'($urandom);
    r.rx_id    = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      if ($urandom_range(0, 2) == 0) r.dest_id = BCAST_ID;
    end else if (pick < 45) begin
      r.opcode = OP_ACK;
    end else if (pick < 67) begin
      r.opcode  = OP_PARSE;
      r.rx_type = cfg_mirror.strobe_type_code;
      case ($urandom_range(0, 3))
        0, 1: r.rx_id = cfg_mirror.own_id;
        2:    r.rx_id = BCAST_ID;
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0: r.rx_count = 8'd0;
        1: r.rx_count = 8'hFF;
        2, 3: r.rx_count = 8'($urandom_range(1, 6));
        default: ;
      endcase
    end else if (pick < 90) begin
      r.opcode  = OP_PARSE;
      r.rx_type = cfg_mirror.ack_type_code;
      if ($urandom_range(0, 4) != 0) r.dest_id = r.rx_id;
      if ($urandom_range(0, 3) != 0) r.rx_count = uni_cnt + 8'd1;
    end else begin
      r.opcode = 2'($urandom_range(0, 3));
    end
    return r;
  endfunction

  task automatic load_config(input cfg_flavor_t flavor);
    cfg_t c;
    c.own_id           = ($urandom_range(0, 3) == 0) ? BCAST_ID : 16'($urandom);
    c.strobe_max       = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    c.broadcast_max    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    c.strobe_interval  = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    c.transition_time  = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
    c.strobe_type_code = 8'($urandom);
    c.ack_type_code    = ($urandom_range(0, 4) == 0) ? c.strobe_type_code : 8'($urandom);
    if (flavor == CFG_ALL_ZERO) c = '0;
    if (flavor == CFG_ALL_ONES) c = '1;
    write_reg(REG_OWN_ID, 32'(c.own_id));
    write_reg(REG_STROBE_MAX, 32'(c.strobe_max));
    write_reg(REG_BCAST_MAX, 32'(c.broadcast_max));
    write_reg(REG_INTERVAL, 32'(c.strobe_interval));
    write_reg(REG_TRANS, 32'(c.transition_time));
    write_reg(REG_STROBE_TYPE, 32'(c.strobe_type_code));
    write_reg(REG_ACK_TYPE, 32'(c.ack_type_code));
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // Registers read back their reset values; both counters start at their
  // reload value and an ACK built right after reset is empty.
  task automatic test_reset_state();
    for (int i = 0; i <= REG_ACK_TYPE; i++) begin
      readback_reg(reg_idx_t'(i));
    end
    send_req(mk_req(OP_STROBE, 16'h0000, 8'h00, 8'h00, 16'h0000));
    send_req(mk_req(OP_STROBE, BCAST_ID, 8'hFF, 8'hFF, 16'hFFFF));
    send_req(mk_req(OP_ACK, 16'hA5A5, 8'h5A, 8'hC3, 16'h3C3C));
  endtask

  // A matching ACK reloads the unicast counter, which then counts down to zero,
  // reports the last strobe and reloads.
  task automatic test_counter_wrap();
    drain();
    write_reg(REG_STROBE_MAX, 32'd1);
    send_req(mk_req(OP_PARSE, 16'h1234, cfg_mirror.ack_type_code, uni_cnt + 8'd1, 16'h1234));
    repeat (3) send_req(mk_req(OP_STROBE, 16'h1234, 8'h00, 8'h00, 16'h0000));
  endtask

  // ACK construction after a strobe for this node, after a broadcast strobe with
  // a zero count, and once more after the pending delay has been consumed.
  task automatic test_ack_paths();
    send_req(mk_req(OP_PARSE, 16'h0000, cfg_mirror.strobe_type_code, 8'd5, cfg_mirror.own_id));
    send_req(mk_req(OP_ACK, 16'h0000, 8'h00, 8'h00, 16'h0000));
    send_req(mk_req(OP_PARSE, 16'h0000, cfg_mirror.strobe_type_code, 8'd0, BCAST_ID));
    send_req(mk_req(OP_ACK, 16'h0000, 8'h00, 8'h00, 16'h0000));
    send_req(mk_req(OP_ACK, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF));
  endtask

  // A matching ACK loads the unicast counter with 255; then received frames that are
  // rejected: ACKs with a wrong ID or count (the counter at 255 among them), an
  // unknown type, a strobe for another node, and the unused opcode.
  task automatic test_parse_rejects();
    drain();
    write_reg(REG_STROBE_MAX, 32'd255);
    send_req(mk_req(OP_PARSE, 16'h00F0, cfg_mirror.ack_type_code, uni_cnt + 8'd1, 16'h00F0));
    send_req(mk_req(OP_PARSE, 16'h00F0, cfg_mirror.ack_type_code, 8'hFF, 16'h00F0));
    send_req(mk_req(OP_PARSE, 16'h00F0, cfg_mirror.ack_type_code, 8'h00, 16'h00F0));
    send_req(mk_req(OP_PARSE, 16'h00F0, cfg_mirror.ack_type_code, 8'h00, 16'h00F1));
    send_req(mk_req(OP_PARSE, 16'h0000, 8'hAB, 8'h10, 16'h0000));
    send_req(mk_req(OP_PARSE, 16'h0000, cfg_mirror.strobe_type_code, 8'h10, 16'h5555));
    send_req(mk_req(OP_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF));
  endtask

  // Own ID equal to the broadcast ID, equal type codes, the largest possible
  // delay, and a delay that the turnaround time floors at zero.
  task automatic test_config_corners();
    drain();
    write_reg(REG_OWN_ID, 32'(BCAST_ID));
    write_reg(REG_STROBE_TYPE, 32'hFF);
    write_reg(REG_ACK_TYPE, 32'hFF);
    write_reg(REG_INTERVAL, 32'hFFFF);
    write_reg(REG_TRANS, 32'd0);
    write_reg(REG_BCAST_MAX, 32'd3);
    send_req(mk_req(OP_PARSE, 16'h0000, 8'hFF, 8'hFF, BCAST_ID));
    send_req(mk_req(OP_ACK, 16'h0000, 8'h00, 8'h00, 16'h0000));
    send_req(mk_req(OP_STROBE, BCAST_ID, 8'h00, 8'h00, 16'h0000));
    drain();
    write_reg(REG_TRANS, 32'hFFFF);
    write_reg(REG_INTERVAL, 32'd1);
    send_req(mk_req(OP_PARSE, 16'h0000, 8'hFF, 8'hFF, BCAST_ID));
    send_req(mk_req(OP_ACK, 16'h0000, 8'h00, 8'h00, 16'h0000));
  endtask

  // Random traffic in phases, each with fresh register values; one phase runs
  // with every register at zero and one with every register at all ones.
  task automatic test_random_traffic();
    cfg_flavor_t flavor;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      flavor = (p == 1) ? CFG_ALL_ZERO : (p == 4) ? CFG_ALL_ONES : CFG_TYPICAL;
      load_config(flavor);
      repeat (REQS_PER_PHASE) send_req(random_req());
    end
  endtask

  initial begin
    reset_predictor();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_counter_wrap();
    test_ack_paths();
    test_parse_rejects();
    test_config_corners();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/wsf_pkg.sv
src/wsf_cfg.sv
src/wsf_core.sv
src/wakeup_strobe_framer_unit.sv
test/tb_wakeup_strobe_framer_unit.sv
